@@ rtl/kscs_pkg.sv @@
// kscs_pkg: shared types, codes and sizes of the keyframe spline camera sampler.
// No dependencies; imported by kscs_div, the top level and the testbench.
`default_nettype none

package kscs_pkg;

  // Table size and derived widths
  localparam int MAX_KEYS = 32;
  localparam int KEY_AW   = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);

  // Spline accumulator and product widths (fraction is 16 bits plus a zero sign bit)
  localparam int ACC_W  = 40;
  localparam int FRAC_W = 16;
  localparam int PROD_W = ACC_W + FRAC_W + 1;

  // Divider step counts
  localparam int DIV_CW = 6;
  localparam logic [DIV_CW-1:0] DIV_STEPS_MOD  = DIV_CW'(32);
  localparam logic [DIV_CW-1:0] DIV_STEPS_FRAC = DIV_CW'(FRAC_W);

  // Command codes
  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_CLEAR = 3'd1;
  localparam logic [2:0] CMD_PLAY  = 3'd2;
  localparam logic [2:0] CMD_PAUSE = 3'd3;
  localparam logic [2:0] CMD_STOP  = 3'd4;
  localparam logic [2:0] CMD_SEEK  = 3'd5;
  localparam logic [2:0] CMD_TICK  = 3'd6;

  // Event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_STARTED = 2'd1;
  localparam logic [1:0] EV_ENDED   = 2'd2;
  localparam logic [1:0] EV_DROPPED = 2'd3;

  typedef enum logic [1:0] {
    RUN_IDLE,
    RUN_PLAYING,
    RUN_PAUSED,
    RUN_FINISHED
  } run_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_SHIFT,
    S_INS_WRITE,
    S_TICK_MOD,
    S_SEG_SCAN,
    S_LOAD,
    S_FRAC_START,
    S_FRAC_WAIT,
    S_MUL,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [31:0]        time_value;
    logic signed [31:0] in_pos_x;
    logic signed [31:0] in_pos_y;
    logic signed [31:0] in_pos_z;
    logic signed [15:0] in_rot_a;
    logic signed [15:0] in_rot_b;
    logic signed [15:0] in_rot_c;
    logic signed [15:0] in_rot_d;
    logic [15:0]        in_fov;
    logic signed [15:0] in_exposure;
  } in_item_t;

  typedef struct packed {
    logic               pose_valid;
    logic [1:0]         event_res;
    logic [1:0]         play_state;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [15:0] out_rot_a;
    logic signed [15:0] out_rot_b;
    logic signed [15:0] out_rot_c;
    logic signed [15:0] out_rot_d;
    logic [15:0]        out_fov;
    logic signed [15:0] out_exposure;
  } out_item_t;

  // One keyframe as stored in the table memory
  typedef struct packed {
    logic [31:0]        key_time;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] rot_a;
    logic signed [15:0] rot_b;
    logic signed [15:0] rot_c;
    logic signed [15:0] rot_d;
    logic [15:0]        fov;
    logic signed [15:0] exposure;
  } key_row_t;

  localparam int ROW_W = $bits(key_row_t);

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [31:0]       rem_init;
    logic [31:0]       dividend;
    logic [31:0]       divisor;
    logic [DIV_CW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] rem;
    logic [15:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/kscs_ram.sv @@
// kscs_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module kscs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/kscs_div.sv @@
// kscs_div: restoring divider, one quotient bit per cycle, for modulo and fraction.
// Depends on kscs_pkg.
`default_nettype none

module kscs_div (
  input  logic                clk,
  input  logic                rst_n,
  input  kscs_pkg::div_req_t  req,
  output kscs_pkg::div_rsp_t  rsp
);
  import kscs_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [31:0]       dvd_r, dvd_nxt;
  logic [31:0]       dsr_r, dsr_nxt;
  logic [15:0]       quo_r, quo_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [32:0]       shifted;
  logic [32:0]       trial;

  // One shift-and-subtract step per cycle
  always_comb begin
    shifted  = {rem_r, dvd_r[31]};
    trial    = shifted - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = req.rem_init;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      cnt_nxt  = req.steps;
      quo_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[30:0], 1'b0};
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        quo_nxt = {quo_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - DIV_CW'(1);
      if (cnt_r == DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

@@ rtl/keyframe_spline_camera_sampler.sv @@
// keyframe_spline_camera_sampler: top level, command sequencer, key table and pose math.
// Depends on kscs_pkg, kscs_ram and kscs_div.
//
// The block takes one command transaction at a time and returns exactly one result
// transaction for it; in_stall is high while a command is in work. The keyframe table
// lives in a RAM with one write port, one read port and a registered read; every table
// walk reads a row in one phase and uses it in the next, which sets most of the latency.
// Play, pause, stop, seek, clear, unknown commands and a dropped add go straight to the
// result. Add keyframe searches for the slot, then moves the later rows up one by one
// and writes the new key. A tick with a pose runs the segment search, the four row
// fetches, the divider for the segment fraction (skipped when the fraction is zero)
// and the shared multiplier (three Horner steps per position axis, one blend each for
// the four rotation components, fov and exposure), after a modulo divide when a looping
// playhead wraps. A tick that yields no pose goes straight to the result. A held result
// (out_stall) delays the handoff. loop_enable is written through the cfg port, which
// is always ready.
`default_nettype none

module keyframe_spline_camera_sampler (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  kscs_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kscs_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);
  import kscs_pkg::*;

  // Control state
  seq_state_t        state_r, state_nxt;
  run_state_t        run_r, run_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [31:0]       dur_r, dur_nxt;
  logic [31:0]       ph_r, ph_nxt;
  logic              loop_r;
  logic              rph_r, rph_nxt;
  logic [1:0]        sel_r, sel_nxt;
  logic              blend_r, blend_nxt;
  logic [2:0]        comp_r, comp_nxt;
  logic [1:0]        stg_r, stg_nxt;
  logic              mph_r, mph_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload
  in_item_t                  item_r, item_nxt;
  out_item_t                 res_r, res_nxt;
  out_item_t                 out_r, out_nxt;
  key_row_t                  row_r [4];
  key_row_t                  row_nxt [4];
  logic [KEY_AW-1:0]         lidx_r [4];
  logic [KEY_AW-1:0]         lidx_nxt [4];
  logic [FRAC_W-1:0]         t_r, t_nxt;
  logic signed [ACC_W-1:0]   h_r, h_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;

  // Memory and divider hookup
  logic              ram_we;
  logic [KEY_AW-1:0] ram_waddr;
  logic [KEY_AW-1:0] ram_raddr;
  key_row_t          ram_wdata;
  key_row_t          ram_rdata;
  logic [ROW_W-1:0]  ram_rbits;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // Datapath helpers
  logic                      accept;
  logic [32:0]               ph_sum;
  logic [31:0]               ph_sat;
  logic [CNT_W-1:0]          seg_ip1, seg_j, seg_jp1, seg_i0, seg_i3;
  logic [31:0]               span, t_i;
  logic signed [ACC_W-1:0]   p0, p1, p2, p3;
  logic signed [ACC_W-1:0]   ca, cb, cc, cd;
  logic signed [ACC_W-1:0]   la, lb;
  logic signed [ACC_W-1:0]   op_a, op_add;
  logic signed [ACC_W-1:0]   h_step, h_half;
  logic signed [FRAC_W:0]    t_s;
  logic [31:0]               pos_sat;

  kscs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_KEYS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  assign ram_rdata = key_row_t'(ram_rbits);

  kscs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  function automatic logic signed [ACC_W-1:0] pos_of(key_row_t r, logic [2:0] k);
    logic signed [31:0] v;
    case (k)
      3'd0:    v = r.pos_x;
      3'd1:    v = r.pos_y;
      default: v = r.pos_z;
    endcase
    return ACC_W'(v);
  endfunction

  function automatic logic signed [ACC_W-1:0] lin_of(key_row_t r, logic [2:0] k);
    logic signed [ACC_W-1:0] v;
    case (k)
      3'd0:    v = ACC_W'(r.rot_a);
      3'd1:    v = ACC_W'(r.rot_b);
      3'd2:    v = ACC_W'(r.rot_c);
      3'd3:    v = ACC_W'(r.rot_d);
      3'd4:    v = ACC_W'($signed({1'b0, r.fov}));
      default: v = ACC_W'(r.exposure);
    endcase
    return v;
  endfunction

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // Saturating playhead advance
  assign ph_sum = {1'b0, ph_r} + {1'b0, in_data.time_value};
  assign ph_sat = ph_sum[32] ? 32'hFFFF_FFFF : ph_sum[31:0];

  // Segment neighbors from the found index
  assign seg_ip1 = idx_r + CNT_W'(1);
  assign seg_j   = (seg_ip1 < cnt_r) ? seg_ip1 : cnt_r - CNT_W'(1);
  assign seg_jp1 = seg_j + CNT_W'(1);
  assign seg_i0  = (idx_r == '0) ? '0 : idx_r - CNT_W'(1);
  assign seg_i3  = (seg_jp1 < cnt_r) ? seg_jp1 : seg_j;

  assign t_i  = row_r[1].key_time;
  assign span = row_r[2].key_time - t_i;

  // Catmull-Rom coefficients of the current axis
  always_comb begin
    p0 = pos_of(row_r[0], comp_r);
    p1 = pos_of(row_r[1], comp_r);
    p2 = pos_of(row_r[2], comp_r);
    p3 = pos_of(row_r[3], comp_r);
    ca = p1 + p1;
    cb = p2 - p0;
    cc = p0 + p0 - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
    cd = p1 + (p1 <<< 1) - p0 - p2 - (p2 <<< 1) + p3;
    la = lin_of(row_r[1], comp_r);
    lb = lin_of(row_r[2], comp_r);
  end

  // Shared multiplier operands
  always_comb begin
    if (blend_r) begin
      op_a   = lb - la;
      op_add = la;
    end else begin
      case (stg_r)
        2'd0: begin
          op_a   = cd;
          op_add = cc;
        end
        2'd1: begin
          op_a   = h_r;
          op_add = cb;
        end
        default: begin
          op_a   = h_r;
          op_add = ca;
        end
      endcase
    end
  end

  assign t_s      = $signed({1'b0, t_r});
  assign prod_nxt = op_a * t_s;
  assign h_step   = ACC_W'(prod_r >>> FRAC_W) + op_add;
  assign h_half   = h_step >>> 1;
  assign pos_sat  = ((h_half[ACC_W-1:31] == '0) || (h_half[ACC_W-1:31] == '1)) ?
                    h_half[31:0] : (h_half[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    run_nxt       = run_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    dur_nxt       = dur_r;
    ph_nxt        = ph_r;
    rph_nxt       = rph_r;
    sel_nxt       = sel_r;
    blend_nxt     = blend_r;
    comp_nxt      = comp_r;
    stg_nxt       = stg_r;
    mph_nxt       = mph_r;
    out_valid_nxt = out_valid_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    row_nxt       = row_r;
    lidx_nxt      = lidx_r;
    t_nxt         = t_r;
    h_nxt         = h_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = ram_rdata;
    ram_raddr     = '0;
    div_req       = '0;

    // Output register drains independently
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt  = in_data;
          res_nxt   = '0;
          state_nxt = S_DONE;
          case (in_data.command)
            CMD_ADD: begin
              if (cnt_r == CNT_W'(MAX_KEYS)) begin
                res_nxt.event_res = EV_DROPPED;
              end else begin
                idx_nxt   = '0;
                rph_nxt   = 1'b0;
                state_nxt = S_INS_SCAN;
              end
            end
            CMD_CLEAR: begin
              cnt_nxt = '0;
              dur_nxt = '0;
            end
            CMD_PLAY: begin
              run_nxt           = RUN_PLAYING;
              ph_nxt            = '0;
              res_nxt.event_res = EV_STARTED;
            end
            CMD_PAUSE: begin
              if (run_r == RUN_PLAYING) begin
                run_nxt = RUN_PAUSED;
              end
            end
            CMD_STOP: begin
              run_nxt = RUN_IDLE;
              ph_nxt  = '0;
            end
            CMD_SEEK: begin
              ph_nxt = (in_data.time_value < dur_r) ? in_data.time_value : dur_r;
            end
            CMD_TICK: begin
              if (run_r == RUN_PLAYING && cnt_r >= CNT_W'(2)) begin
                idx_nxt   = '0;
                rph_nxt   = 1'b0;
                state_nxt = S_SEG_SCAN;
                ph_nxt    = ph_sat;
                if (ph_sat >= dur_r) begin
                  if (loop_r) begin
                    if (dur_r == '0) begin
                      ph_nxt = '0;
                    end else begin
                      div_req.start    = 1'b1;
                      div_req.rem_init = '0;
                      div_req.dividend = ph_sat;
                      div_req.divisor  = dur_r;
                      div_req.steps    = DIV_STEPS_MOD;
                      state_nxt        = S_TICK_MOD;
                    end
                  end else begin
                    ph_nxt            = dur_r;
                    run_nxt           = RUN_FINISHED;
                    res_nxt.event_res = EV_ENDED;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Find first slot whose time is not below the new time
      S_INS_SCAN: begin
        if (idx_r == cnt_r) begin
          pos_nxt   = idx_r;
          idx_nxt   = cnt_r;
          rph_nxt   = 1'b0;
          state_nxt = S_INS_SHIFT;
        end else if (!rph_r) begin
          ram_raddr = idx_r[KEY_AW-1:0];
          rph_nxt   = 1'b1;
        end else begin
          rph_nxt = 1'b0;
          if (ram_rdata.key_time < item_r.time_value) begin
            idx_nxt = idx_r + CNT_W'(1);
          end else begin
            pos_nxt   = idx_r;
            idx_nxt   = cnt_r;
            state_nxt = S_INS_SHIFT;
          end
        end
      end

      // Move rows at and above the slot up by one, top first
      S_INS_SHIFT: begin
        if (idx_r == pos_r) begin
          state_nxt = S_INS_WRITE;
        end else if (!rph_r) begin
          ram_raddr = KEY_AW'(idx_r - CNT_W'(1));
          rph_nxt   = 1'b1;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = idx_r[KEY_AW-1:0];
          ram_wdata = ram_rdata;
          idx_nxt   = idx_r - CNT_W'(1);
          rph_nxt   = 1'b0;
        end
      end

      S_INS_WRITE: begin
        ram_we             = 1'b1;
        ram_waddr          = pos_r[KEY_AW-1:0];
        ram_wdata.key_time = item_r.time_value;
        ram_wdata.pos_x    = item_r.in_pos_x;
        ram_wdata.pos_y    = item_r.in_pos_y;
        ram_wdata.pos_z    = item_r.in_pos_z;
        ram_wdata.rot_a    = item_r.in_rot_a;
        ram_wdata.rot_b    = item_r.in_rot_b;
        ram_wdata.rot_c    = item_r.in_rot_c;
        ram_wdata.rot_d    = item_r.in_rot_d;
        ram_wdata.fov      = item_r.in_fov;
        ram_wdata.exposure = item_r.in_exposure;
        cnt_nxt            = cnt_r + CNT_W'(1);
        // Appended at the end: the new key sets the duration
        if (pos_r == cnt_r) begin
          dur_nxt = item_r.time_value;
        end
        state_nxt = S_DONE;
      end

      S_TICK_MOD: begin
        if (div_rsp.done) begin
          ph_nxt    = div_rsp.rem;
          state_nxt = S_SEG_SCAN;
        end
      end

      // Last key whose time is at or before the playhead
      S_SEG_SCAN: begin
        if (seg_ip1 >= cnt_r) begin
          lidx_nxt[0] = seg_i0[KEY_AW-1:0];
          lidx_nxt[1] = idx_r[KEY_AW-1:0];
          lidx_nxt[2] = seg_j[KEY_AW-1:0];
          lidx_nxt[3] = seg_i3[KEY_AW-1:0];
          sel_nxt     = '0;
          rph_nxt     = 1'b0;
          state_nxt   = S_LOAD;
        end else if (!rph_r) begin
          ram_raddr = seg_ip1[KEY_AW-1:0];
          rph_nxt   = 1'b1;
        end else begin
          rph_nxt = 1'b0;
          if (ram_rdata.key_time <= ph_r) begin
            idx_nxt = seg_ip1;
          end else begin
            lidx_nxt[0] = seg_i0[KEY_AW-1:0];
            lidx_nxt[1] = idx_r[KEY_AW-1:0];
            lidx_nxt[2] = seg_j[KEY_AW-1:0];
            lidx_nxt[3] = seg_i3[KEY_AW-1:0];
            sel_nxt     = '0;
            state_nxt   = S_LOAD;
          end
        end
      end

      // Fetch the four control rows
      S_LOAD: begin
        if (!rph_r) begin
          ram_raddr = lidx_r[sel_r];
          rph_nxt   = 1'b1;
        end else begin
          row_nxt[sel_r] = ram_rdata;
          rph_nxt        = 1'b0;
          if (sel_r == 2'd3) begin
            state_nxt = S_FRAC_START;
          end else begin
            sel_nxt = sel_r + 2'd1;
          end
        end
      end

      S_FRAC_START: begin
        blend_nxt = 1'b0;
        comp_nxt  = '0;
        stg_nxt   = '0;
        mph_nxt   = 1'b0;
        if (span != '0 && ph_r > t_i) begin
          div_req.start    = 1'b1;
          div_req.rem_init = ph_r - t_i;
          div_req.dividend = '0;
          div_req.divisor  = span;
          div_req.steps    = DIV_STEPS_FRAC;
          state_nxt        = S_FRAC_WAIT;
        end else begin
          t_nxt     = '0;
          state_nxt = S_MUL;
        end
      end

      S_FRAC_WAIT: begin
        if (div_rsp.done) begin
          t_nxt     = div_rsp.quo;
          state_nxt = S_MUL;
        end
      end

      // Product registered in the first phase, shifted and added in the second
      S_MUL: begin
        if (!mph_r) begin
          mph_nxt = 1'b1;
        end else begin
          mph_nxt = 1'b0;
          h_nxt   = h_step;
          if (!blend_r) begin
            if (stg_r == 2'd2) begin
              case (comp_r)
                3'd0:    res_nxt.out_pos_x = pos_sat;
                3'd1:    res_nxt.out_pos_y = pos_sat;
                default: res_nxt.out_pos_z = pos_sat;
              endcase
              stg_nxt = '0;
              if (comp_r == 3'd2) begin
                blend_nxt = 1'b1;
                comp_nxt  = '0;
              end else begin
                comp_nxt = comp_r + 3'd1;
              end
            end else begin
              stg_nxt = stg_r + 2'd1;
            end
          end else begin
            case (comp_r)
              3'd0:    res_nxt.out_rot_a    = h_step[15:0];
              3'd1:    res_nxt.out_rot_b    = h_step[15:0];
              3'd2:    res_nxt.out_rot_c    = h_step[15:0];
              3'd3:    res_nxt.out_rot_d    = h_step[15:0];
              3'd4:    res_nxt.out_fov      = h_step[15:0];
              default: res_nxt.out_exposure = h_step[15:0];
            endcase
            if (comp_r == 3'd5) begin
              res_nxt.pose_valid = 1'b1;
              state_nxt          = S_DONE;
            end else begin
              comp_nxt = comp_r + 3'd1;
            end
          end
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt            = res_r;
          out_nxt.play_state = run_r;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= RUN_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      pos_r       <= '0;
      dur_r       <= '0;
      ph_r        <= '0;
      loop_r      <= 1'b0;
      rph_r       <= 1'b0;
      sel_r       <= '0;
      blend_r     <= 1'b0;
      comp_r      <= '0;
      stg_r       <= '0;
      mph_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      pos_r       <= pos_nxt;
      dur_r       <= dur_nxt;
      ph_r        <= ph_nxt;
      rph_r       <= rph_nxt;
      sel_r       <= sel_nxt;
      blend_r     <= blend_nxt;
      comp_r      <= comp_nxt;
      stg_r       <= stg_nxt;
      mph_r       <= mph_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        loop_r <= cfg_data;
      end
    end
    item_r <= item_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    row_r  <= row_nxt;
    lidx_r <= lidx_nxt;
    t_r    <= t_nxt;
    h_r    <= h_nxt;
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

@@ tb/keyframe_spline_camera_sampler_checker.sv @@
// Checker for the keyframe spline camera sampler: watches the command and result
// channels, predicts each result and compares it. Depends on kscs_pkg.
`timescale 1ns / 100ps

module keyframe_spline_camera_sampler_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  kscs_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  kscs_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_data,
  output int                  fail_count,
  output int                  pending_poses
);
  import kscs_pkg::*;

  // Shadow copy of the keyframe table and playback state
  logic [31:0]        kt_time [MAX_KEYS];
  logic signed [31:0] kt_pos  [MAX_KEYS][3];
  logic signed [15:0] kt_rot  [MAX_KEYS][4];
  logic [15:0]        kt_fov  [MAX_KEYS];
  logic signed [15:0] kt_exp  [MAX_KEYS];
  int unsigned        n_keys;
  logic [31:0]        duration;
  logic [31:0]        head;
  run_state_t         run;
  logic               looping;

  out_item_t expected_poses[$];

  function automatic longint fdiv16(longint x);
    return x >>> 16;
  endfunction

  function automatic logic signed [31:0] catmull(longint p0, longint p1, longint p2,
                                                 longint p3, longint t);
    longint a, b, c, d, h;
    a = 2 * p1;
    b = p2 - p0;
    c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    d = -p0 + 3 * p1 - 3 * p2 + p3;
    h = fdiv16(d * t) + c;
    h = fdiv16(h * t) + b;
    h = fdiv16(h * t) + a;
    h = h >>> 1;
    if (h > 64'sd2147483647) h = 64'sd2147483647;
    if (h < -64'sd2147483648) h = -64'sd2147483648;
    return h[31:0];
  endfunction

  function automatic logic [15:0] lerp16(longint a, longint b, longint t);
    longint r;
    r = fdiv16(a * (65536 - t) + b * t);
    return r[15:0];
  endfunction

  // Sorted insert ahead of keys with an equal time; drop when full
  function automatic void insert_key(input in_item_t it, inout out_item_t r);
    int unsigned slot;
    if (n_keys >= MAX_KEYS) begin
      r.event_res = EV_DROPPED;
      return;
    end
    slot = 0;
    while (slot < n_keys && kt_time[slot] < it.time_value) slot++;
    for (int k = n_keys; k > slot; k--) begin
      kt_time[k] = kt_time[k-1];
      kt_pos[k]  = kt_pos[k-1];
      kt_rot[k]  = kt_rot[k-1];
      kt_fov[k]  = kt_fov[k-1];
      kt_exp[k]  = kt_exp[k-1];
    end
    kt_time[slot] = it.time_value;
    kt_pos[slot][0] = it.in_pos_x;
    kt_pos[slot][1] = it.in_pos_y;
    kt_pos[slot][2] = it.in_pos_z;
    kt_rot[slot][0] = it.in_rot_a;
    kt_rot[slot][1] = it.in_rot_b;
    kt_rot[slot][2] = it.in_rot_c;
    kt_rot[slot][3] = it.in_rot_d;
    kt_fov[slot] = it.in_fov;
    kt_exp[slot] = it.in_exposure;
    n_keys++;
    duration = kt_time[n_keys-1];
  endfunction

  // Advance playhead and sample the pose
  function automatic void sample_pose(input logic [31:0] step, inout out_item_t r);
    int unsigned i, j, i0, i3;
    logic [31:0] span;
    longint t;
    logic signed [31:0] pv [3];
    logic [15:0] rv [4];
    if (run != RUN_PLAYING || n_keys < 2) return;
    head = (head > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : head + step;
    if (head >= duration) begin
      if (looping) head = (duration != 0) ? head % duration : 32'd0;
      else begin
        head = duration;
        run = RUN_FINISHED;
        r.event_res = EV_ENDED;
      end
    end
    i = 0;
    while (i + 1 < n_keys && kt_time[i+1] <= head) i++;
    j = (i + 1 < n_keys) ? i + 1 : n_keys - 1;
    span = kt_time[j] - kt_time[i];
    t = 0;
    if (span > 0 && head > kt_time[i])
      t = longint'(({32'd0, head - kt_time[i]} << 16) / {32'd0, span});
    i0 = (i != 0) ? i - 1 : 0;
    i3 = (j + 1 < n_keys) ? j + 1 : j;
    for (int c = 0; c < 3; c++)
      pv[c] = catmull(longint'(kt_pos[i0][c]), longint'(kt_pos[i][c]),
                      longint'(kt_pos[j][c]), longint'(kt_pos[i3][c]), t);
    for (int c = 0; c < 4; c++)
      rv[c] = lerp16(longint'(kt_rot[i][c]), longint'(kt_rot[j][c]), t);
    r.pose_valid = 1'b1;
    r.out_pos_x = pv[0];
    r.out_pos_y = pv[1];
    r.out_pos_z = pv[2];
    r.out_rot_a = rv[0];
    r.out_rot_b = rv[1];
    r.out_rot_c = rv[2];
    r.out_rot_d = rv[3];
    r.out_fov = lerp16(longint'(kt_fov[i]), longint'(kt_fov[j]), t);
    r.out_exposure = lerp16(longint'(kt_exp[i]), longint'(kt_exp[j]), t);
  endfunction

  function automatic out_item_t predict_result(input in_item_t it);
    out_item_t r;
    r = '0;
    case (it.command)
      CMD_ADD: insert_key(it, r);
      CMD_CLEAR: begin
        n_keys = 0;
        duration = 0;
      end
      CMD_PLAY: begin
        run = RUN_PLAYING;
        head = 0;
        r.event_res = EV_STARTED;
      end
      CMD_PAUSE: if (run == RUN_PLAYING) run = RUN_PAUSED;
      CMD_STOP: begin
        run = RUN_IDLE;
        head = 0;
      end
      CMD_SEEK: head = (it.time_value < duration) ? it.time_value : duration;
      CMD_TICK: sample_pose(it.time_value, r);
      default: ;
    endcase
    r.play_state = run;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  // Watch channels at each rising edge
  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      n_keys = 0;
      duration = 0;
      head = 0;
      run = RUN_IDLE;
      looping = 1'b0;
      fail_count = 0;
      expected_poses.delete();
    end else begin
      if (cfg_valid && cfg_ready) looping = cfg_data;
      if (in_valid && !in_stall) expected_poses = {expected_poses, predict_result(in_data)};
      if (out_valid && !out_stall) begin
        if (expected_poses.size() == 0) begin
          report_mismatch("unexpected result", out_data[63:0], 64'd0);
        end else begin
          e = expected_poses.pop_front();
          if (out_data.pose_valid !== e.pose_valid)
            report_mismatch("pose_valid", 64'(out_data.pose_valid), 64'(e.pose_valid));
          if (out_data.event_res !== e.event_res)
            report_mismatch("event_res", 64'(out_data.event_res), 64'(e.event_res));
          if (out_data.play_state !== e.play_state)
            report_mismatch("play_state", 64'(out_data.play_state), 64'(e.play_state));
          if (out_data.out_pos_x !== e.out_pos_x)
            report_mismatch("out_pos_x", 64'(out_data.out_pos_x), 64'(e.out_pos_x));
          if (out_data.out_pos_y !== e.out_pos_y)
            report_mismatch("out_pos_y", 64'(out_data.out_pos_y), 64'(e.out_pos_y));
          if (out_data.out_pos_z !== e.out_pos_z)
            report_mismatch("out_pos_z", 64'(out_data.out_pos_z), 64'(e.out_pos_z));
          if (out_data.out_rot_a !== e.out_rot_a)
            report_mismatch("out_rot_a", 64'(out_data.out_rot_a), 64'(e.out_rot_a));
          if (out_data.out_rot_b !== e.out_rot_b)
            report_mismatch("out_rot_b", 64'(out_data.out_rot_b), 64'(e.out_rot_b));
          if (out_data.out_rot_c !== e.out_rot_c)
            report_mismatch("out_rot_c", 64'(out_data.out_rot_c), 64'(e.out_rot_c));
          if (out_data.out_rot_d !== e.out_rot_d)
            report_mismatch("out_rot_d", 64'(out_data.out_rot_d), 64'(e.out_rot_d));
          if (out_data.out_fov !== e.out_fov)
            report_mismatch("out_fov", 64'(out_data.out_fov), 64'(e.out_fov));
          if (out_data.out_exposure !== e.out_exposure)
            report_mismatch("out_exposure", 64'(out_data.out_exposure),
                            64'(e.out_exposure));
        end
      end
    end
    pending_poses = expected_poses.size();
  end

endmodule

@@ tb/keyframe_spline_camera_sampler_test.sv @@
// Testbench top for the keyframe spline camera sampler: clock, reset, command stimulus,
// loop setting and verdict. Depends on kscs_pkg and keyframe_spline_camera_sampler_checker.
`timescale 1ns / 100ps

module keyframe_spline_camera_sampler_test;
  import kscs_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;
  int        fail_count;
  int        pending_poses;
  bit        hold_off_req;

  keyframe_spline_camera_sampler u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  keyframe_spline_camera_sampler_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_poses(pending_poses)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit: ~1850 items, many times over their worst-case run time
  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    bit hold_done;
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else begin
        mode = int'(($time / 20000) % 3);
        if (mode == 0) out_stall <= 1'b0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 1) == 0);
      end
    end
  end

  function automatic in_item_t rand_item(input logic [2:0] cmd);
    in_item_t it;
    it.command     = cmd;
    it.time_value  = $urandom;
    it.in_pos_x    = $urandom;
    it.in_pos_y    = $urandom;
    it.in_pos_z    = $urandom;
    it.in_rot_a    = 16'($urandom);
    it.in_rot_b    = 16'($urandom);
    it.in_rot_c    = 16'($urandom);
    it.in_rot_d    = 16'($urandom);
    it.in_fov      = 16'($urandom);
    it.in_exposure = 16'($urandom);
    return it;
  endfunction

  // Offer one command transaction and wait until accepted
  task automatic send_cmd(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Loop setting change, only with nothing outstanding
  task automatic set_looping(input logic on);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_poses != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= on;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_key(input logic [31:0] kt);
    in_item_t it;
    it = rand_item(CMD_ADD);
    it.time_value = kt;
    send_cmd(it);
  endtask

  task automatic send_simple(input logic [2:0] cmd, input logic [31:0] tv);
    in_item_t it;
    it = rand_item(cmd);
    it.time_value = tv;
    send_cmd(it);
  endtask

  initial begin
    in_item_t it;
    int sent, burst, nk, r;
    logic [31:0] span_max;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    hold_off_req = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty-table ticks, unknown code, equal times, extremes, end of track
    send_simple(CMD_TICK, 32'h0001_0000);
    send_simple(CMD_PLAY, 0);
    send_simple(CMD_TICK, 32'h0001_0000);
    send_simple(3'd7, 0);
    it = '0;
    it.command = CMD_ADD;
    it.time_value = 32'h0002_0000;
    it.in_pos_x = 32'h7FFF_FFFF;
    it.in_pos_y = 32'h8000_0000;
    it.in_rot_a = 16'h7FFF;
    it.in_rot_b = 16'h8000;
    it.in_fov = 16'hFFFF;
    it.in_exposure = 16'h8000;
    send_cmd(it);
    it.in_pos_x = 32'h8000_0000;
    it.in_pos_y = 32'h7FFF_FFFF;
    it.in_fov = 16'h0000;
    it.in_exposure = 16'h7FFF;
    it.time_value = 32'h0004_0000;
    send_cmd(it);
    send_key(32'h0002_0000);
    send_key(32'h0000_0000);
    send_simple(CMD_TICK, 32'h0000_8000);
    send_simple(CMD_PAUSE, 0);
    send_simple(CMD_TICK, 32'h0000_8000);
    send_simple(CMD_PAUSE, 0);
    send_simple(CMD_PLAY, 0);
    send_simple(CMD_SEEK, 32'hFFFF_FFFF);
    send_simple(CMD_TICK, 32'hFFFF_FFFF);
    send_simple(CMD_TICK, 32'h0000_1000);
    send_simple(CMD_STOP, 0);
    set_looping(1'b1);
    send_simple(CMD_PLAY, 0);
    send_simple(CMD_TICK, 32'hFFFF_FFFF);
    send_simple(CMD_TICK, 32'h0003_0000);
    send_simple(CMD_CLEAR, 0);
    send_key(0);
    send_key(0);
    send_simple(CMD_TICK, 32'h0000_0100);
    sent = 25;

    // Random phases: build a track, play it, with occasional noise and overfill
    while (sent < 1850) begin
      if ($urandom_range(0, 3) == 0) set_looping(1'($urandom_range(0, 1)));
      if (sent > 600 && sent < 700) hold_off_req = 1'b1;
      send_simple(CMD_CLEAR, 0);
      sent++;
      nk = ($urandom_range(0, 7) == 0) ? 34 : $urandom_range(0, 8);
      span_max = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : 32'h0010_0000;
      for (int k = 0; k < nk; k++) begin
        send_key(($urandom_range(0, 4) == 0) ? 32'd0 : $urandom_range(0, span_max));
        sent++;
      end
      send_simple(CMD_PLAY, 0);
      sent++;
      burst = $urandom_range(1, 8);
      for (int k = 0; k < 40; k++) begin
        r = $urandom_range(0, 19);
        if (r < 14) send_simple(CMD_TICK, ($urandom_range(0, 9) == 0) ? $urandom
                                           : $urandom_range(0, span_max >> 3));
        else if (r == 14) send_simple(CMD_PAUSE, 0);
        else if (r == 15) send_simple(CMD_PLAY, 0);
        else if (r == 16) send_simple(CMD_SEEK, $urandom);
        else if (r == 17) send_simple(CMD_STOP, 0);
        else if (r == 18) send_cmd(rand_item(3'($urandom_range(0, 7))));
        else send_key($urandom);
        sent++;
        burst--;
        if (burst == 0) begin
          idle_gap($urandom_range(0, 6));
          burst = $urandom_range(1, 8);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_poses != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
